// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, quiet while reset is high
`define PLPP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("playhead assertion failed");

// concurrent assertion that is also checked during reset
`define PLPP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("playhead assertion failed");

`endif

// ===== rtl/plpp_pkg.sv =====
// shared types and constants for the playhead loop / ping-pong core
// no dependencies; compiled before every other file
`default_nettype none

package plpp_pkg;

   // fixed field widths
   localparam int KIND_W            = 3;
   localparam int DELTA_W           = 24;
   localparam int SEEK_W            = 32;
   localparam int POS_W             = 32;
   localparam int SPEED_W           = 16;
   localparam int STEP_W            = 32;
   localparam int SPEED_FRAC        = 8;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int TIME_BITS_DEFAULT = 32;

   // command kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK   = 3'd0,
      KIND_PLAY   = 3'd1,
      KIND_STOP   = 3'd2,
      KIND_PAUSE  = 3'd3,
      KIND_RESUME = 3'd4,
      KIND_SEEK   = 3'd5
   } kind_type;

   // run state
   typedef enum logic [1:0] {
      RUN_STOPPED = 2'd0,
      RUN_PLAYING = 2'd1,
      RUN_PAUSED  = 2'd2
   } run_type;

   // loop modes
   localparam logic [1:0] MODE_ONCE     = 2'd0;
   localparam logic [1:0] MODE_LOOP     = 2'd1;
   localparam logic [1:0] MODE_PINGPONG = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DURATION = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOADED   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED    = 3'd3;

   // register reset values
   localparam logic [1:0]         MODE_RESET  = MODE_LOOP;
   localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [DELTA_W-1:0] delta;
      logic [SEEK_W-1:0]  seek_time;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [1:0]       run_state;
      logic             reversing;
      logic             reached_end;
   } rsp_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_APPLY,
      ST_DIV,
      ST_DIV_END,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mul;
      logic apply;
      logic div_start;
      logic div_step;
      logic div_end;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_div;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/plpp_ctrl.sv =====
// controller state machine for the playhead core
// depends on plpp_pkg
`default_nettype none

module plpp_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  plpp_pkg::sts_type   sts,
   output plpp_pkg::cmd_type   cmd
);
   import plpp_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (sts.needs_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.apply = 1'b1;
               state_in  = ST_OUT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            cmd.div_end = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/plpp_dp.sv =====
// datapath: registers, step multiplier, playhead update, remainder unit
// depends on plpp_pkg
`default_nettype none

module plpp_dp #(
   parameter int TIME_BITS = plpp_pkg::TIME_BITS_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  plpp_pkg::req_type                    req_payload,
   input  wire                                  csr_write,
   input  wire  [plpp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [plpp_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output plpp_pkg::rsp_type                    rsp_payload,
   input  plpp_pkg::cmd_type                    cmd,
   output plpp_pkg::sts_type                    sts
);
   import plpp_pkg::*;

   // sum width holds any position plus any step without overflow
   localparam int SUM_W = ((TIME_BITS > STEP_W) ? TIME_BITS : STEP_W) + 1;
   localparam int CNT_W = $clog2(SUM_W);
   localparam logic [SUM_W-1:0] TMAX_S = {{(SUM_W-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

   // limit a wide value to the largest time value
   function automatic logic [TIME_BITS-1:0] clamp_time(input logic [SUM_W-1:0] v);
      logic [TIME_BITS-1:0] r;
      if (v > TMAX_S) begin
         r = '1;
      end else begin
         r = v[TIME_BITS-1:0];
      end
      return r;
   endfunction

   // configuration registers
   logic [CSR_DATA_W-1:0] duration_ff;
   logic                  loaded_ff;
   logic [1:0]            mode_ff;
   logic [SPEED_W-1:0]    speed_ff;

   // item registers
   logic [KIND_W-1:0]  kind_ff;
   logic [DELTA_W-1:0] delta_ff;
   logic [SEEK_W-1:0]  seek_ff;
   logic [STEP_W-1:0]  step_ff;

   // playhead state
   logic [TIME_BITS-1:0] pos_ff, pos_in;
   run_type              run_ff, run_in;
   logic                 rev_ff, rev_in;
   logic                 ended_ff, ended_in;

   // remainder unit
   logic [SUM_W-1:0]     num_ff;
   logic [TIME_BITS-1:0] rem_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [TIME_BITS:0]   trial;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   logic [DELTA_W+SPEED_W-1:0] prod;
   logic [TIME_BITS-1:0]       dur;
   logic [SUM_W-1:0]           pos_ext, step_ext, dur_ext, sum;
   logic [TIME_BITS-1:0]       sat, seek_c;
   logic [SUM_W-1:0]           pos_wide;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= '0;
         loaded_ff   <= 1'b0;
         mode_ff     <= MODE_RESET;
         speed_ff    <= SPEED_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DURATION: duration_ff <= csr_data;
            CSR_LOADED:   loaded_ff   <= csr_data[0];
            CSR_MODE:     mode_ff     <= csr_data[1:0];
            CSR_SPEED:    speed_ff    <= csr_data[SPEED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // capture the transaction and form the scaled step
   assign prod = delta_ff * speed_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_payload.kind;
         delta_ff <= req_payload.delta;
         seek_ff  <= req_payload.seek_time;
      end
      if (cmd.mul) begin
         step_ff <= prod[SPEED_FRAC +: STEP_W];
      end
   end

   // effective duration, common widths, saturated sum, clamped seek
   always_comb begin
      dur_ext  = loaded_ff ? SUM_W'(duration_ff) : '0;
      dur      = clamp_time(dur_ext);
      pos_ext  = SUM_W'(pos_ff);
      step_ext = SUM_W'(step_ff);
      sum      = pos_ext + step_ext;
      sat      = clamp_time(sum);
      seek_c   = clamp_time(SUM_W'(seek_ff));
      if ((dur != '0) && (seek_c > dur)) begin
         seek_c = dur;
      end
   end

   assign sts.needs_div = (kind_type'(kind_ff) == KIND_TICK) && (run_ff == RUN_PLAYING) &&
                          (dur != '0) && (mode_ff == MODE_LOOP);
   assign sts.div_last  = (cnt_ff == CNT_LAST);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // playhead update
   always_comb begin
      pos_in   = pos_ff;
      run_in   = run_ff;
      rev_in   = rev_ff;
      ended_in = ended_ff;
      pos_wide = '0;
      if (cmd.apply) begin
         ended_in = 1'b0;
         case (kind_type'(kind_ff))
            KIND_TICK: begin
               if ((run_ff == RUN_PLAYING) && (dur != '0)) begin
                  case (mode_ff)
                     MODE_ONCE: begin
                        if (sat >= dur) begin
                           pos_in   = dur;
                           run_in   = RUN_STOPPED;
                           ended_in = 1'b1;
                        end else begin
                           pos_in = sat;
                        end
                     end
                     MODE_PINGPONG: begin
                        if (!rev_ff) begin
                           if (sat >= dur) begin
                              pos_in = dur;
                              rev_in = 1'b1;
                           end else begin
                              pos_in = sat;
                           end
                        end else if (step_ext >= pos_ext) begin
                           pos_in = '0;
                           rev_in = 1'b0;
                        end else begin
                           pos_wide = pos_ext - step_ext;
                           pos_in   = pos_wide[TIME_BITS-1:0];
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            KIND_PLAY: begin
               if (loaded_ff) begin
                  run_in = RUN_PLAYING;
                  pos_in = '0;
                  rev_in = 1'b0;
               end
            end
            KIND_STOP: begin
               run_in = RUN_STOPPED;
               pos_in = '0;
               rev_in = 1'b0;
            end
            KIND_PAUSE: begin
               if (run_ff == RUN_PLAYING) begin
                  run_in = RUN_PAUSED;
               end
            end
            KIND_RESUME: begin
               if (run_ff == RUN_PAUSED) begin
                  run_in = RUN_PLAYING;
               end
            end
            KIND_SEEK: begin
               pos_in = seek_c;
            end
            default: begin
            end
         endcase
      end else if (cmd.div_start) begin
         ended_in = 1'b0;
      end else if (cmd.div_end) begin
         pos_in = rem_ff;
      end
   end

   // playhead state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         run_ff   <= RUN_STOPPED;
         rev_ff   <= 1'b0;
         ended_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         run_ff   <= run_in;
         rev_ff   <= rev_in;
         ended_ff <= ended_in;
      end
   end

   // restoring remainder, one dividend bit per cycle, msb first
   assign trial = {rem_ff, num_ff[SUM_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         num_ff <= sum;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[SUM_W-2:0], 1'b0};
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (trial >= {1'b0, dur}) begin
            rem_ff <= TIME_BITS'(trial - {1'b0, dur});
         end else begin
            rem_ff <= trial[TIME_BITS-1:0];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.position    <= pos_ext[POS_W-1:0];
         rsp_ff.run_state   <= run_ff;
         rsp_ff.reversing   <= rev_ff;
         rsp_ff.reached_end <= ended_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/playhead_loop_pingpong_core.sv =====
// playhead core: command sequencing around a time-position datapath
// Sequence: a request is accepted in idle, then the step is multiplied and applied, and the
// response is registered; a playing wrap-mode tick first runs a modulo, one bit per cycle.
// A new request is not accepted until the previous one has been loaded into the output
// register, and that load waits for a finished response in the register to drain.
// Reset: synchronous; registers go to their reset values, playhead to 0, stopped.
`default_nettype none

module playhead_loop_pingpong_core #(
   parameter int TIME_BITS = plpp_pkg::TIME_BITS_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  plpp_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output plpp_pkg::rsp_type                rsp_payload,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [plpp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [plpp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import plpp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // registers are always writable
   assign csr_ready = 1'b1;

   plpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   plpp_dp #(
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

`default_nettype wire

// ===== rtl/plpp_checker.sv =====
// port-level checks for the playhead core, bound to the top level
// depends on plpp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module plpp_checker (
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_ready,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input plpp_pkg::rsp_type  rsp_payload
);
   import plpp_pkg::*;

   // a pending response holds its payload
   `PLPP_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))

   // one transaction in flight: no acceptance right after another
   `PLPP_ASSERT(a_req_single, clock, reset, (req_valid && req_ready) |=> !req_ready)

   // end of clip is only reported together with the stopped state
   `PLPP_ASSERT(a_end_stopped, clock, reset, (rsp_valid && rsp_payload.reached_end) |-> (rsp_payload.run_state == RUN_STOPPED))

   // no response comes straight out of reset
   `PLPP_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid)

endmodule

bind playhead_loop_pingpong_core plpp_checker u_plpp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
